[src/psfp_pkg.sv]
package psfp_pkg;

	localparam int FRAME_BYTES = 32;
	localparam int DATA_WORDS  = 13;
	localparam int DATA_START  = 4;

	localparam int POS_W   = $clog2(FRAME_BYTES);
	localparam int WADDR_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

	localparam logic [7:0]  START_FIRST  = 8'h42;
	localparam logic [7:0]  START_SECOND = 8'h4D;
	localparam logic [15:0] START_SUM    = 16'(START_FIRST) + 16'(START_SECOND);

	typedef struct packed {
		logic               en;
		logic [WADDR_W-1:0] addr;
		logic [15:0]        data;
	} wr_port_t;

	typedef struct packed {
		logic        start;
		logic [15:0] length;
		logic        good;
	} frame_done_t;

endpackage

[src/psfp_if.sv]
interface psfp_in_if ();
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface psfp_out_if ();
	logic        valid;
	logic        ready;
	logic [3:0]  word_index;
	logic [15:0] word_value;
	logic [15:0] length_field;
	logic        checksum_good;
	logic        last_word;

	modport source (
		output valid, output word_index, output word_value, output length_field,
		output checksum_good, output last_word, input ready
	);
	modport sink (
		input valid, input word_index, input word_value, input length_field,
		input checksum_good, input last_word, output ready
	);
endinterface

[src/psfp_collector.sv]
module psfp_collector import psfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_fire,
	input  logic [7:0]  rx_byte,
	output logic        idle,
	output wr_port_t    wr,
	output frame_done_t done
);

	localparam logic C_IDLE = 1'b0;
	localparam logic C_PROC = 1'b1;

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_SECOND  = 2'd1;
	localparam logic [1:0] PH_COLLECT = 2'd2;

	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] POS_CHK   = POS_W'(FRAME_BYTES - 2);
	localparam logic [POS_W-1:0] POS_LEN_H = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LEN_L = POS_W'(3);
	localparam logic [POS_W-1:0] POS_DATA  = POS_W'(DATA_START);

	logic             state_q;
	logic [1:0]       phase_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      sum_q;
	logic [7:0]       hold_q;
	logic [15:0]      length_q;
	logic [7:0]       chk_high_q;
	logic [7:0]       byte_q;

	logic [15:0]      sum_add;
	logic [POS_W-1:0] off;
	logic [POS_W-1:0] wnum;
	logic             proc;

	// sum adder: running byte sum
	assign sum_add = sum_q + {8'h00, byte_q};
	assign off     = pos_q - POS_DATA;
	assign wnum    = off >> 1;
	assign proc    = (state_q == C_PROC) && (phase_q == PH_COLLECT);
	assign idle    = (state_q == C_IDLE);

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = WADDR_W'(wnum);
		wr.data = {hold_q, byte_q};
		if (proc && pos_q != POS_LAST && pos_q != POS_CHK && pos_q != POS_LEN_H
				&& pos_q != POS_LEN_L && pos_q >= POS_DATA && off[0]
				&& int'(wnum) < DATA_WORDS) begin
			wr.en = 1'b1;
		end
	end

	always_comb begin
		done.start  = proc && (pos_q == POS_LAST);
		done.length = length_q;
		done.good   = ({chk_high_q, byte_q} == sum_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= C_IDLE;
			phase_q    <= PH_HUNT;
			pos_q      <= '0;
			sum_q      <= '0;
			hold_q     <= '0;
			length_q   <= '0;
			chk_high_q <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (byte_fire) begin
						state_q <= C_PROC;
					end
				end
				C_PROC: begin
					state_q <= C_IDLE;
					unique case (phase_q)
						PH_HUNT: begin
							if (byte_q == START_FIRST) begin
								phase_q <= PH_SECOND;
							end
						end
						PH_SECOND: begin
							if (byte_q == START_SECOND) begin
								phase_q <= PH_COLLECT;
								pos_q   <= POS_LEN_H;
								sum_q   <= START_SUM;
							end else if (byte_q != START_FIRST) begin
								phase_q <= PH_HUNT;
							end
						end
						PH_COLLECT: begin
							if (pos_q < POS_CHK) begin
								sum_q <= sum_add;
							end
							if (pos_q == POS_LAST) begin
								phase_q <= PH_HUNT;
								pos_q   <= '0;
							end else begin
								pos_q <= pos_q + 1'b1;
								if (pos_q == POS_CHK) begin
									chk_high_q <= byte_q;
								end else if (pos_q == POS_LEN_H) begin
									hold_q <= byte_q;
								end else if (pos_q == POS_LEN_L) begin
									length_q <= {hold_q, byte_q};
								end else if (pos_q >= POS_DATA && !off[0]
										&& int'(wnum) < DATA_WORDS) begin
									hold_q <= byte_q;
								end
							end
						end
						default: begin
							phase_q <= PH_HUNT;
						end
					endcase
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (byte_fire) begin
			byte_q <= rx_byte;
		end
	end

endmodule

[src/psfp_emitter.sv]
module psfp_emitter import psfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  wr_port_t    wr,
	input  frame_done_t done,
	output logic        busy,
	psfp_out_if.source  tx
);

	localparam logic [1:0] E_IDLE = 2'd0;
	localparam logic [1:0] E_READ = 2'd1;
	localparam logic [1:0] E_LOAD = 2'd2;

	localparam logic [WADDR_W-1:0] IDX_LAST = WADDR_W'(DATA_WORDS - 1);

	logic [15:0]        mem [DATA_WORDS];
	logic [15:0]        rdata_q;
	logic [1:0]         state_q;
	logic [WADDR_W-1:0] idx_q;
	logic [15:0]        length_q;
	logic               good_q;

	logic               out_valid_q;
	logic [3:0]         out_index_q;
	logic [15:0]        out_value_q;
	logic [15:0]        out_length_q;
	logic               out_good_q;
	logic               out_last_q;

	logic               load;

	assign busy = (state_q != E_IDLE);
	assign load = (state_q == E_LOAD) && (!out_valid_q || tx.ready);

	assign tx.valid         = out_valid_q;
	assign tx.word_index    = out_index_q;
	assign tx.word_value    = out_value_q;
	assign tx.length_field  = out_length_q;
	assign tx.checksum_good = out_good_q;
	assign tx.last_word     = out_last_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				E_IDLE: begin
					if (done.start) begin
						state_q <= E_READ;
						idx_q   <= '0;
					end
				end
				E_READ: begin
					state_q <= E_LOAD;
				end
				E_LOAD: begin
					if (load) begin
						if (idx_q == IDX_LAST) begin
							state_q <= E_IDLE;
						end else begin
							state_q <= E_READ;
							idx_q   <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done.start && state_q == E_IDLE) begin
			length_q <= done.length;
			good_q   <= done.good;
		end
		if (load) begin
			out_index_q  <= 4'(idx_q);
			out_value_q  <= rdata_q;
			out_length_q <= length_q;
			out_good_q   <= good_q;
			out_last_q   <= (idx_q == IDX_LAST);
		end
	end

endmodule

[src/particle_sensor_frame_parser.sv]
// Each byte is accepted into a register, then processed before the next is taken; bytes
// ahead of the checksum go through the sum adder. After the final byte, each word is read
// from the word store, then loaded into the output register when empty or tx is ready.
// No byte is taken from the final byte until the last word is loaded.
// arst_n clears the sequencers, sum, length and hold bytes; the word store is not cleared.
module particle_sensor_frame_parser import psfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	psfp_in_if.sink    rx,
	psfp_out_if.source tx
);

	logic        coll_idle;
	logic        emit_busy;
	logic        byte_fire;
	wr_port_t    wr;
	frame_done_t done;

	assign rx.ready  = coll_idle && !emit_busy;
	assign byte_fire = rx.valid && rx.ready;

	psfp_collector u_collector (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_fire (byte_fire),
		.rx_byte   (rx.rx_byte),
		.idle      (coll_idle),
		.wr        (wr),
		.done      (done)
	);

	psfp_emitter u_emitter (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.done   (done),
		.busy   (emit_busy),
		.tx     (tx)
	);

endmodule
